// File: hdl/query_param_decoder_core_macros.svh
// ------------------------------------------------------------------------
// Assertion macros for the query parameter decoder
// Shared wrappers so every asserting module reports in the same way.
// ------------------------------------------------------------------------
`ifndef QUERY_PARAM_DECODER_CORE_MACROS_SVH
`define QUERY_PARAM_DECODER_CORE_MACROS_SVH

// Check a property on every clock edge outside reset
`define QPD_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every clock edge, reset included
`define QPD_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/qpd_pkg.sv
// ------------------------------------------------------------------------
// qpd_pkg
// Types, character codes and helper functions of the query decoder.
// ------------------------------------------------------------------------
package qpd_pkg;

   // Characters with a meaning of their own in a query string
   localparam logic [7:0] CharPercent = 8'h25;
   localparam logic [7:0] CharPlus    = 8'h2B;
   localparam logic [7:0] CharEquals  = 8'h3D;
   localparam logic [7:0] CharAmp     = 8'h26;
   localparam logic [7:0] CharUnder   = 8'h5F;
   localparam logic [7:0] CharSpace   = 8'h20;

   // Radix of a percent escape and the width of one digit
   localparam int HexRadix = 16;
   localparam int HexBits  = $clog2(HexRadix);

   typedef enum logic [1:0] {
      KIND_KEY    = 2'd0,
      KIND_VALUE  = 2'd1,
      KIND_COMMIT = 2'd2,
      KIND_DROP   = 2'd3
   } kind_type;

   typedef struct packed {
      logic [7:0] data;
      kind_type   kind;
      logic       last;
   } result_type;

   // Results of one item: zero, one or two, in delivery order
   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } push_type;

   function automatic logic hex_valid(input logic [7:0] c);
      hex_valid = (c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
   endfunction

   function automatic logic [HexBits-1:0] hex_value(input logic [7:0] c);
      logic [7:0] v;
      v = 8'h00;
      if (c inside {[8'h30:8'h39]}) begin
         v = c - 8'h30;
      end else if (c inside {[8'h41:8'h46]}) begin
         v = c - 8'h37;
      end else if (c inside {[8'h61:8'h66]}) begin
         v = c - 8'h57;
      end
      hex_value = v[HexBits-1:0];
   endfunction

   // Upper-case letters, keep digits, turn everything else into '_'
   function automatic logic [7:0] key_char(input logic [7:0] c);
      logic [7:0] k;
      k = c;
      if (c inside {[8'h61:8'h7A]}) begin
         k = c - 8'h20;
      end
      if (!(k inside {[8'h41:8'h5A], [8'h30:8'h39]})) begin
         k = CharUnder;
      end
      key_char = k;
   endfunction

endpackage

// File: hdl/qpd_req_if.sv
// ------------------------------------------------------------------------
// qpd_req_if
// Input channel: one query byte per item with its end-of-query flag.
// ------------------------------------------------------------------------
interface qpd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       end_of_query;

   modport source (output valid, output in_byte, output end_of_query, input ready);
   modport sink   (input valid, input in_byte, input end_of_query, output ready);
endinterface

// File: hdl/qpd_rsp_if.sv
// ------------------------------------------------------------------------
// qpd_rsp_if
// Result channel: key bytes, value bytes and pair markers.
// ------------------------------------------------------------------------
interface qpd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic [1:0] out_kind;
   logic       last;

   modport source (output valid, output out_byte, output out_kind, output last,
                   input ready);
   modport sink   (input valid, input out_byte, input out_kind, input last,
                   output ready);
endinterface

// File: hdl/qpd_step.sv
// ------------------------------------------------------------------------
// qpd_step
// Parser state and the per-byte decode that yields up to two results.
// ------------------------------------------------------------------------
module qpd_step (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept_i,
   input  logic [7:0]        in_byte_i,
   input  logic              end_of_query_i,
   output qpd_pkg::push_type push_o
);
   import qpd_pkg::*;

   typedef enum logic [1:0] {
      PH_KEY   = 2'd0,
      PH_VALUE = 2'd1,
      PH_ESC1  = 2'd2,
      PH_ESC2  = 2'd3
   } phase_type;

   phase_type          phase_ff, phase_in;
   logic               hex_ok_ff, hex_ok_in;
   logic [HexBits-1:0] hex_hi_ff, hex_hi_in;
   logic               trunc_ff, trunc_in;

   logic               emit_req;
   logic [7:0]         emit_byte;
   logic               data_push;
   logic [7:0]         data_byte;
   kind_type           data_kind;
   logic               mark_push;
   kind_type           mark_kind;
   result_type         data_res, mark_res;

   // Decode one byte against the current phase
   always_comb begin
      phase_in  = phase_ff;
      hex_ok_in = hex_ok_ff;
      hex_hi_in = hex_hi_ff;
      trunc_in  = trunc_ff;
      emit_req  = 1'b0;
      emit_byte = 8'h00;
      data_push = 1'b0;
      data_byte = 8'h00;
      data_kind = KIND_KEY;
      mark_push = 1'b0;
      mark_kind = KIND_COMMIT;

      case (phase_ff)
         PH_KEY: begin
            if (in_byte_i == CharEquals || in_byte_i == CharAmp) begin
               phase_in  = PH_VALUE;
               hex_ok_in = 1'b0;
               hex_hi_in = '0;
               trunc_in  = 1'b0;
               mark_push = end_of_query_i;
               mark_kind = KIND_COMMIT;
            end else begin
               data_push = 1'b1;
               data_byte = key_char(in_byte_i);
               data_kind = KIND_KEY;
               mark_push = end_of_query_i;
               mark_kind = KIND_DROP;
            end
         end
         PH_VALUE: begin
            if (in_byte_i == CharAmp) begin
               mark_push = 1'b1;
               phase_in  = PH_KEY;
               hex_ok_in = 1'b0;
               hex_hi_in = '0;
               trunc_in  = 1'b0;
            end else begin
               if (in_byte_i == CharPercent) begin
                  phase_in  = PH_ESC1;
                  hex_ok_in = 1'b0;
                  hex_hi_in = '0;
                  emit_req  = end_of_query_i;
                  emit_byte = 8'h00;
               end else begin
                  emit_req  = 1'b1;
                  emit_byte = (in_byte_i == CharPlus) ? CharSpace : in_byte_i;
               end
               mark_push = end_of_query_i;
            end
         end
         PH_ESC1: begin
            hex_ok_in = hex_valid(in_byte_i);
            hex_hi_in = hex_value(in_byte_i);
            phase_in  = PH_ESC2;
            emit_req  = end_of_query_i;
            emit_byte = {{(8-HexBits){1'b0}}, hex_value(in_byte_i)};
            mark_push = end_of_query_i;
         end
         PH_ESC2: begin
            if (!hex_ok_ff) begin
               emit_byte = 8'h00;
            end else if (hex_valid(in_byte_i)) begin
               emit_byte = {hex_hi_ff, hex_value(in_byte_i)};
            end else begin
               emit_byte = {{(8-HexBits){1'b0}}, hex_hi_ff};
            end
            emit_req  = 1'b1;
            phase_in  = PH_VALUE;
            hex_ok_in = 1'b0;
            hex_hi_in = '0;
            mark_push = end_of_query_i;
         end
         default: begin
            phase_in = PH_KEY;
         end
      endcase

      // Drop value bytes once a zero byte has truncated the value
      if (emit_req && !trunc_ff) begin
         if (emit_byte == 8'h00) begin
            trunc_in = 1'b1;
         end else begin
            data_push = 1'b1;
            data_byte = emit_byte;
            data_kind = KIND_VALUE;
         end
      end

      // Return to the reset state after the final byte
      if (end_of_query_i) begin
         phase_in  = PH_KEY;
         hex_ok_in = 1'b0;
         hex_hi_in = '0;
         trunc_in  = 1'b0;
      end
   end

   // Pack results in order; flag the final one
   always_comb begin
      data_res = '{data: data_byte, kind: data_kind, last: !mark_push};
      mark_res = '{data: 8'h00, kind: mark_kind, last: 1'b1};
      push_o   = '0;
      if (data_push) begin
         push_o.first  = data_res;
         push_o.second = mark_res;
         push_o.count  = mark_push ? 2'd2 : 2'd1;
      end else begin
         push_o.first  = mark_res;
         push_o.second = mark_res;
         push_o.count  = mark_push ? 2'd1 : 2'd0;
      end
   end

   // Hold parser state; advance on each accepted item
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_KEY;
         hex_ok_ff <= 1'b0;
         hex_hi_ff <= '0;
         trunc_ff  <= 1'b0;
      end else if (accept_i) begin
         phase_ff  <= phase_in;
         hex_ok_ff <= hex_ok_in;
         hex_hi_ff <= hex_hi_in;
         trunc_ff  <= trunc_in;
      end
   end

endmodule

// File: hdl/qpd_outq.sv
// ------------------------------------------------------------------------
// qpd_outq
// Two-slot result buffer that hands results out one per cycle while they are taken.
// ------------------------------------------------------------------------
`include "query_param_decoder_core_macros.svh"

module qpd_outq (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_i,
   input  qpd_pkg::push_type   push_data_i,
   output logic                ready_o,
   output logic                valid_o,
   input  logic                take_i,
   output qpd_pkg::result_type head_o
);
   import qpd_pkg::*;

   logic [1:0] cnt_ff, cnt_in;
   result_type slot0_ff, slot0_in;
   result_type slot1_ff, slot1_in;
   logic       pop;

   // Take a new item only when the buffer drains this cycle
   assign pop     = (cnt_ff != 2'd0) && take_i;
   assign ready_o = (cnt_ff == 2'd0) || ((cnt_ff == 2'd1) && take_i);
   assign valid_o = (cnt_ff != 2'd0);
   assign head_o  = slot0_ff;

   // Load fresh results, or shift the second slot forward
   always_comb begin
      cnt_in   = cnt_ff;
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      if (push_i) begin
         cnt_in   = push_data_i.count;
         slot0_in = push_data_i.first;
         slot1_in = push_data_i.second;
      end else if (pop) begin
         cnt_in   = cnt_ff - 2'd1;
         slot0_in = slot1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

   `QPD_ASSERT(a_cnt_range, clock, reset, cnt_ff != 2'd3, "result count out of range")
   `QPD_ASSERT(a_push_empty, clock, reset, push_i |-> (cnt_ff == 2'd0 || pop), "push into occupied buffer")
   `QPD_ASSERT(a_last_second, clock, reset, (cnt_ff == 2'd2) |-> (!slot0_ff.last && slot1_ff.last), "pair of results without last on the second")
   `QPD_ASSERT_ALWAYS(a_reset_empty, clock, $past(reset) |-> (cnt_ff == 2'd0), "buffer not empty after reset")

endmodule

// File: hdl/query_param_decoder_core.sv
// Latency: a result is offered on the cycle after its input item is accepted.
// Throughput: one item per cycle while each yields at most one result and
// the result channel is ready; an item yielding two results holds the input
// until the single-result port takes the second from the two-slot buffer.
// Reset: synchronous, active high; returns the parser to the key phase and
// empties the result buffer.
// ------------------------------------------------------------------------
// query_param_decoder_core
// Splits a query string into normalised keys and percent-decoded values.
// ------------------------------------------------------------------------
module query_param_decoder_core (
   input logic       clock,
   input logic       reset,
   qpd_req_if.sink   req_port,
   qpd_rsp_if.source rsp_port
);
   import qpd_pkg::*;

   logic       accept;
   logic       buf_ready;
   push_type   step_push;
   result_type head;

   // Accept an item whenever the buffer can take its results
   assign req_port.ready = buf_ready;
   assign accept         = req_port.valid && buf_ready;

   qpd_step u_step (
      .clock          (clock),
      .reset          (reset),
      .accept_i       (accept),
      .in_byte_i      (req_port.in_byte),
      .end_of_query_i (req_port.end_of_query),
      .push_o         (step_push)
   );

   qpd_outq u_outq (
      .clock       (clock),
      .reset       (reset),
      .push_i      (accept),
      .push_data_i (step_push),
      .ready_o     (buf_ready),
      .valid_o     (rsp_port.valid),
      .take_i      (rsp_port.ready),
      .head_o      (head)
   );

   // Drive the result channel from the buffer head
   assign rsp_port.out_byte = head.data;
   assign rsp_port.out_kind = head.kind;
   assign rsp_port.last     = head.last;

endmodule
